// ----- rtl/pstb_pkg.sv -----
// Package with shared constants and types for the periodic timer bank.
`timescale 1ns / 1ps
`default_nettype none

package pstb_pkg;

	localparam int NUM_CHANNELS = 16;
	localparam int MAX_RESULTS  = 16;
	localparam int CH_IW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

	localparam int PERIOD_W = 16;
	localparam int CD_W     = 18;

	localparam logic [2:0] OP_ENABLE   = 3'd0;
	localparam logic [2:0] OP_STOP     = 3'd1;
	localparam logic [2:0] OP_CONTINUE = 3'd2;
	localparam logic [2:0] OP_QUERY    = 3'd3;
	localparam logic [2:0] OP_TICK     = 3'd4;

	localparam logic [3:0] STEP_ONE = 4'd1;
	localparam logic [3:0] STEP_TEN = 4'd10;

	typedef struct packed {
		logic        [PERIOD_W-1:0] period;
		logic signed [CD_W-1:0]     countdown;
	} ent_t;

endpackage

`default_nettype wire

// ----- rtl/periodic_soft_timer_bank_top.sv -----
// Periodic timer bank: command decode, per-tick channel sweep over the state memory, result output.
// A command result is registered and presented in the cycle after its transaction is accepted.
// Commands are accepted while the bank is idle and the output register is free.
// A tick sweeps the channel memory at one entry per cycle unless an expiry waits on a busy output
// (one read port, one write port), so no new item is taken until the sweep and its flush are done.
// Reset: run flags and entry-written flags clear at once; no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none

module periodic_soft_timer_bank_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // channel[3:0], period_ms[19:4], tick_is_ten[20], zero pad
	input  wire logic [2:0]  s_tuser,  // op[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // out_channel[3:0], running[4], zero pad
	output logic             m_tuser,  // fired[0]
	output logic             m_tlast
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	localparam logic [2:0] OP_ENABLE_C   = pstb_pkg::OP_ENABLE;
	localparam logic [2:0] OP_STOP_C     = pstb_pkg::OP_STOP;
	localparam logic [2:0] OP_CONTINUE_C = pstb_pkg::OP_CONTINUE;

	localparam int NCH  = pstb_pkg::NUM_CHANNELS;
	localparam int IW   = pstb_pkg::CH_IW;
	localparam int CW   = pstb_pkg::CNT_W;
	localparam int CD_W = pstb_pkg::CD_W;

	// input fields
	logic [2:0]  op;
	logic [3:0]  channel;
	logic [15:0] period_ms;
	logic        tick_is_ten;

	assign op          = s_tuser;
	assign channel     = s_tdata[3:0];
	assign period_ms   = s_tdata[19:4];
	assign tick_is_ten = s_tdata[20];

	logic [1:0]          state_q;
	logic [NCH-1:0]      run_q;
	logic [NCH-1:0]      wr_q;
	logic [3:0]          step_q;
	logic [IW-1:0]       idx_s1;
	logic                pend_q;
	logic [IW-1:0]       pend_ch_q;
	logic [CW-1:0]       cnt_q;

	logic                out_vld_q;
	logic [3:0]          out_ch_q;
	logic                out_run_q;
	logic                out_fired_q;
	logic                out_last_q;

	pstb_pkg::ent_t      mem [NCH];
	pstb_pkg::ent_t      rd_data_s1;

	logic                out_free;
	logic                out_load;
	logic                in_acc;
	logic                cmd_valid;
	logic [IW-1:0]       cmd_idx;
	logic                cmd_run;

	logic                mem_we;
	logic [IW-1:0]       mem_wa;
	pstb_pkg::ent_t      mem_wd;
	logic                rd_en;
	logic [IW-1:0]       rd_addr;

	logic                ch_run;
	logic [15:0]         ch_per;
	logic signed [CD_W-1:0] ch_cd;
	logic signed [CD_W:0]   cd_next;
	logic                expired;
	logic                capture;
	logic                advance;
	logic                idx_last;

	assign out_free  = !out_vld_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && out_free;
	assign in_acc    = s_tvalid && s_tready;

	assign cmd_valid = int'(channel) < NCH;
	assign cmd_idx   = IW'(channel);

	always_comb begin
		cmd_run = 1'b0;
		if (cmd_valid) begin
			case (op)
				OP_ENABLE_C, OP_CONTINUE_C: cmd_run = 1'b1;
				OP_STOP_C:                  cmd_run = 1'b0;
				default:                    cmd_run = run_q[cmd_idx];
			endcase
		end
	end

	// channel under evaluation; never-written entries read as zero
	assign ch_run   = run_q[idx_s1];
	assign ch_per   = wr_q[idx_s1] ? rd_data_s1.period : '0;
	assign ch_cd    = wr_q[idx_s1] ? rd_data_s1.countdown : '0;
	assign cd_next  = {ch_cd[CD_W-1], ch_cd} - $signed({{(CD_W-3){1'b0}}, step_q});
	assign expired  = ch_run && cd_next[CD_W];
	assign capture  = expired && (cnt_q < CW'(pstb_pkg::MAX_RESULTS));
	// stall only when a pending expiry must go out and the output is busy
	assign advance  = (state_q == ST_SWEEP) && !(capture && pend_q && !out_free);
	assign idx_last = idx_s1 == IW'(NCH - 1);

	// load the output register with a new transaction
	assign out_load = ((state_q == ST_IDLE) && in_acc && op != pstb_pkg::OP_TICK)
		|| (advance && capture && pend_q)
		|| ((state_q == ST_FLUSH) && out_free);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_s1;
		mem_wd = '{period: ch_per, countdown: expired
			? $signed({2'b00, ch_per}) - 18'sd1 : cd_next[CD_W-1:0]};
		rd_en   = 1'b0;
		rd_addr = '0;
		if (state_q == ST_IDLE) begin
			if (in_acc && op == OP_ENABLE_C && cmd_valid) begin
				mem_we = 1'b1;
				mem_wa = cmd_idx;
				mem_wd = '{period: period_ms,
					countdown: $signed({2'b00, period_ms}) - 18'sd1};
			end
			if (in_acc && op == pstb_pkg::OP_TICK) begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
		end else if (advance) begin
			mem_we = ch_run;
			if (!idx_last) begin
				rd_en   = 1'b1;
				rd_addr = idx_s1 + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			run_q       <= '0;
			wr_q        <= '0;
			step_q      <= pstb_pkg::STEP_ONE;
			idx_s1      <= '0;
			pend_q      <= 1'b0;
			pend_ch_q   <= '0;
			cnt_q       <= '0;
			out_vld_q   <= 1'b0;
			out_ch_q    <= '0;
			out_run_q   <= 1'b0;
			out_fired_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (mem_we) begin
				wr_q[mem_wa] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (op == pstb_pkg::OP_TICK) begin
							step_q  <= tick_is_ten ? pstb_pkg::STEP_TEN : pstb_pkg::STEP_ONE;
							idx_s1  <= '0;
							pend_q  <= 1'b0;
							cnt_q   <= '0;
							state_q <= ST_SWEEP;
						end else begin
							if (cmd_valid && (op == OP_ENABLE_C || op == OP_CONTINUE_C)) begin
								run_q[cmd_idx] <= 1'b1;
							end else if (cmd_valid && op == OP_STOP_C) begin
								run_q[cmd_idx] <= 1'b0;
							end
							out_ch_q    <= channel;
							out_run_q   <= cmd_run;
							out_fired_q <= 1'b0;
							out_last_q  <= 1'b1;
						end
					end
				end
				ST_SWEEP: begin
					if (advance) begin
						if (capture) begin
							// emit the previous expiry now that a later one exists
							if (pend_q) begin
								out_ch_q    <= 4'(pend_ch_q);
								out_run_q   <= 1'b1;
								out_fired_q <= 1'b1;
								out_last_q  <= 1'b0;
							end
							pend_q    <= 1'b1;
							pend_ch_q <= idx_s1;
							cnt_q     <= cnt_q + 1'b1;
						end
						if (idx_last) begin
							state_q <= ST_FLUSH;
						end else begin
							idx_s1 <= idx_s1 + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						out_ch_q    <= pend_q ? 4'(pend_ch_q) : 4'd0;
						out_run_q   <= pend_q;
						out_fired_q <= pend_q;
						out_last_q  <= 1'b1;
						pend_q      <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {3'b000, out_run_q, out_ch_q};
	assign m_tuser  = out_fired_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_IDLE)
		else $error("input ready outside idle");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(pstb_pkg::MAX_RESULTS))
		else $error("expiry count overflow");

	a_pend_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == ST_SWEEP || state_q == ST_FLUSH))
		else $error("pending expiry outside a tick");

	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op == pstb_pkg::OP_TICK) |=> (state_q == ST_SWEEP && idx_s1 == '0))
		else $error("tick did not start sweep");

	a_sweep_write: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q == ST_SWEEP) |-> (run_q[idx_s1] && mem_wa == idx_s1))
		else $error("sweep wrote a stopped channel");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the periodic timer bank: stream driver, monitor and timer predictor.
`timescale 1ns / 1ps
`default_nettype none

module tb;

	localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
	localparam logic [2:0] OP_RESERVED_MID   = 3'd6;
	localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;
	localparam int         CYCLE_LIMIT       = 400000;
	localparam int         HOLD_CYCLES       = 400;
	localparam int         DRAIN_CYCLES      = 40;

	typedef struct packed {
		logic [2:0]                    op;
		logic [pstb_pkg::CH_IW-1:0]    ch;
		logic [pstb_pkg::PERIOD_W-1:0] period;
		logic                          ten;
	} timer_cmd_t;

	typedef struct packed {
		logic                       fired;
		logic [pstb_pkg::CH_IW-1:0] ch;
		logic                       running;
		logic                       last;
	} timer_evt_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;  // channel[3:0], period_ms[19:4], tick_is_ten[20], zero pad
	logic [2:0]  s_tuser  = '0;  // op[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // out_channel[3:0], running[4], zero pad
	logic        m_tuser;        // fired[0]
	logic        m_tlast;

	timer_cmd_t cmd_queue[$];
	timer_evt_t pending_events[$];
	timer_cmd_t offered;
	timer_evt_t want;
	bit         in_taken  = 1'b0;
	bit         long_hold = 1'b0;
	int         tx_gap    = 0;
	int         rx_gap    = 0;
	int         n_in      = 0;
	int         n_total   = 0;
	int         errors    = 0;
	int         cycles    = 0;

	// predictor state
	logic                             run_q    [pstb_pkg::NUM_CHANNELS];
	logic [pstb_pkg::PERIOD_W-1:0]    reload_q [pstb_pkg::NUM_CHANNELS];
	logic signed [pstb_pkg::CD_W-1:0] cd_q     [pstb_pkg::NUM_CHANNELS];

	periodic_soft_timer_bank_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	task automatic report_mismatch(string what, int got, int exp_val);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, exp_val);
		errors++;
	endtask

	task automatic queue_cmd(logic [2:0] op, int ch, int period, int ten);
		timer_cmd_t c;
		c.op     = op;
		c.ch     = ch[pstb_pkg::CH_IW-1:0];
		c.period = period[pstb_pkg::PERIOD_W-1:0];
		c.ten    = ten[0];
		cmd_queue.push_back(c);
	endtask

	// Apply one command to the predictor and queue the results it causes.
	function automatic void apply_timer_cmd(timer_cmd_t c);
		logic signed [pstb_pkg::CD_W-1:0] step;
		timer_evt_t                       e;
		int                               n;
		n = 0;
		if (c.op == pstb_pkg::OP_TICK) begin
			step = $signed({{(pstb_pkg::CD_W-4){1'b0}},
				(c.ten ? pstb_pkg::STEP_TEN : pstb_pkg::STEP_ONE)});
			for (int i = 0; i < pstb_pkg::NUM_CHANNELS; i++) begin
				if (run_q[i]) begin
					cd_q[i] = cd_q[i] - step;
					if (cd_q[i] < 0) begin
						// reload drops the leftover count
						cd_q[i] = $signed({2'b00, reload_q[i]}) - 18'sd1;
						if (n < pstb_pkg::MAX_RESULTS) begin
							e.fired   = 1'b1;
							e.ch      = i[pstb_pkg::CH_IW-1:0];
							e.running = 1'b1;
							e.last    = 1'b0;
							pending_events.push_back(e);
							n++;
						end
					end
				end
			end
			if (n == 0) begin
				e = '0;
				e.last = 1'b1;
				pending_events.push_back(e);
			end else begin
				pending_events[pending_events.size() - 1].last = 1'b1;
			end
		end else begin
			case (c.op)
				pstb_pkg::OP_ENABLE: begin
					reload_q[c.ch] = c.period;
					cd_q[c.ch]     = $signed({2'b00, c.period}) - 18'sd1;
					run_q[c.ch]    = 1'b1;
				end
				pstb_pkg::OP_STOP:     run_q[c.ch] = 1'b0;
				pstb_pkg::OP_CONTINUE: run_q[c.ch] = 1'b1;
				default: ;
			endcase
			e.fired   = 1'b0;
			e.ch      = c.ch;
			e.running = run_q[c.ch];
			e.last    = 1'b1;
			pending_events.push_back(e);
		end
	endfunction

	// Idle only away from the tail of the run, with quiet windows in between.
	function automatic bit idle_ok();
		return (cmd_queue.size() > 40) && (((cycles >> 8) % 4) != 3);
	endfunction

	initial begin
		for (int i = 0; i < pstb_pkg::NUM_CHANNELS; i++) begin
			run_q[i]    = 1'b0;
			reload_q[i] = '0;
			cd_q[i]     = '0;
		end
	end

	// Stimulus: directed opening, then random commands with occasional full-bank sweeps.
	initial begin
		int pick;
		queue_cmd(pstb_pkg::OP_QUERY, 0, 0, 0);
		queue_cmd(pstb_pkg::OP_TICK, 0, 0, 0);
		queue_cmd(OP_RESERVED_FIRST, 9, 16'h1234, 1);
		queue_cmd(OP_RESERVED_MID, 4, 0, 0);
		queue_cmd(OP_RESERVED_LAST, 15, 16'hFFFF, 1);
		queue_cmd(pstb_pkg::OP_ENABLE, 0, 0, 0);
		queue_cmd(pstb_pkg::OP_ENABLE, 15, 16'hFFFF, 0);
		queue_cmd(pstb_pkg::OP_ENABLE, 3, 1, 0);
		queue_cmd(pstb_pkg::OP_ENABLE, 5, 10, 0);
		queue_cmd(pstb_pkg::OP_TICK, 0, 0, 0);
		queue_cmd(pstb_pkg::OP_TICK, 0, 0, 1);
		queue_cmd(pstb_pkg::OP_STOP, 3, 0, 0);
		queue_cmd(pstb_pkg::OP_QUERY, 3, 0, 0);
		queue_cmd(pstb_pkg::OP_CONTINUE, 3, 0, 0);
		queue_cmd(pstb_pkg::OP_QUERY, 3, 0, 0);
		queue_cmd(pstb_pkg::OP_STOP, 0, 0, 0);
		queue_cmd(pstb_pkg::OP_TICK, 0, 0, 0);
		queue_cmd(pstb_pkg::OP_ENABLE, 7, 16'hAAAA, 1);
		queue_cmd(pstb_pkg::OP_ENABLE, 8, 16'h5555, 0);
		queue_cmd(pstb_pkg::OP_CONTINUE, 0, 0, 0);
		queue_cmd(pstb_pkg::OP_STOP, 12, 0, 1);
		queue_cmd(pstb_pkg::OP_CONTINUE, 12, 0, 0);
		queue_cmd(pstb_pkg::OP_TICK, 15, 16'hFFFF, 1);
		queue_cmd(pstb_pkg::OP_QUERY, 12, 0, 0);
		while (cmd_queue.size() < 280) begin
			pick = $urandom_range(0, 199);
			if (pick < 3) begin
				for (int c = 0; c < pstb_pkg::NUM_CHANNELS; c++)
					queue_cmd(pstb_pkg::OP_ENABLE, c, $urandom_range(0, 3),
						$urandom_range(0, 1));
				repeat ($urandom_range(2, 5))
					queue_cmd(pstb_pkg::OP_TICK, $urandom_range(0, 15), $urandom,
						$urandom_range(0, 1));
			end else if (pick < 85) begin
				queue_cmd(pstb_pkg::OP_TICK, $urandom_range(0, 15), $urandom,
					($urandom_range(0, 9) < 3));
			end else if (pick < 125) begin
				pick = $urandom_range(0, 19);
				queue_cmd(pstb_pkg::OP_ENABLE, $urandom_range(0, 15),
					(pick < 10) ? $urandom_range(0, 25) :
					(pick < 15) ? $urandom_range(0, 65535) :
					(pick < 17) ? 0 : $urandom_range(0, 200),
					$urandom_range(0, 1));
			end else if (pick < 145) begin
				queue_cmd(pstb_pkg::OP_STOP, $urandom_range(0, 15), $urandom,
					$urandom_range(0, 1));
			end else if (pick < 165) begin
				queue_cmd(pstb_pkg::OP_CONTINUE, $urandom_range(0, 15), $urandom,
					$urandom_range(0, 1));
			end else if (pick < 188) begin
				queue_cmd(pstb_pkg::OP_QUERY, $urandom_range(0, 15), $urandom,
					$urandom_range(0, 1));
			end else begin
				queue_cmd(3'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST)),
					$urandom_range(0, 15), $urandom, $urandom_range(0, 1));
			end
		end
		n_total = cmd_queue.size();
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Stall the output long enough for the bank to back up into its input.
	initial begin
		wait (n_in >= 110);
		long_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold = 1'b0;
	end

	// Input driver: hold the offered transaction until it is taken.
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !in_taken)) begin
			if (tx_gap > 0) begin
				s_tvalid <= 1'b0;
				tx_gap--;
			end else if (cmd_queue.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (idle_ok() && $urandom_range(0, 5) == 0) begin
				tx_gap = $urandom_range(0, 16);
				s_tvalid <= 1'b0;
			end else begin
				offered = cmd_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {3'b000, offered.ten, offered.period, offered.ch};
				s_tuser  <= offered.op;
			end
		end
	end

	// Output ready: long hold, random stall bursts, otherwise accept.
	always @(negedge clk) begin
		if (long_hold) begin
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			m_tready <= 1'b0;
			rx_gap--;
		end else if (arst_n && idle_ok() && $urandom_range(0, 4) == 0) begin
			rx_gap = $urandom_range(0, 16);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Monitor: check the output transaction first, then predict the input transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_events.size() == 0) begin
					report_mismatch("result with nothing pending, tdata", int'(m_tdata), 0);
				end else begin
					want = pending_events.pop_front();
					if (m_tuser !== want.fired)
						report_mismatch("fired", int'(m_tuser), int'(want.fired));
					if (m_tdata[3:0] !== want.ch)
						report_mismatch("out_channel", int'(m_tdata[3:0]), int'(want.ch));
					if (m_tdata[4] !== want.running)
						report_mismatch("running", int'(m_tdata[4]), int'(want.running));
					if (m_tlast !== want.last)
						report_mismatch("last", int'(m_tlast), int'(want.last));
				end
			end
			in_taken = s_tvalid && s_tready;
			if (in_taken) begin
				apply_timer_cmd(offered);
				n_in++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int waited;
		wait (n_total > 0 && n_in == n_total);
		waited = 0;
		while (pending_events.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_events.size() != 0)
			report_mismatch("results never delivered", 0, pending_events.size());
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/pstb_pkg.sv
rtl/periodic_soft_timer_bank_top.sv
tb/sv/tb.sv
